FILE: design/ttps_pkg.sv
// ----------------------------------------------------------------------------
// Transposition table package
// Request codes, bound codes, the work item passed from front to back, the
// result item, and the mate score adjustment shared by both sides.
// ----------------------------------------------------------------------------
package ttps_pkg;

  typedef enum logic [1:0] {
    REQ_PROBE = 2'd0,
    REQ_STORE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [1:0] BOUND_NONE  = 2'd0;
  localparam logic [1:0] BOUND_ALPHA = 2'd1;
  localparam logic [1:0] BOUND_BETA  = 2'd2;
  localparam logic [1:0] BOUND_EXACT = 2'd3;

  localparam logic [1:0]  REG_MATE_ADDR = 2'd0;
  localparam logic [14:0] MATE_RESET    = 15'd29936;

  localparam int MID_DEPTH = 2;
  localparam int OQ_DEPTH  = 4;
  localparam int RES_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    req_t               kind;
    logic [63:0]        key;
    logic [5:0]         ply;
    logic [5:0]         depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [24:0]        move;
    logic signed [15:0] score;
    logic [1:0]         bound;
  } work_t;

  typedef struct packed {
    logic               key_matched;
    logic               cutoff;
    logic [24:0]        move;
    logic signed [15:0] score;
  } result_t;

  // Move a mate score away from zero (away = 1) or back toward it by ply,
  // then saturate to 16 bits.
  function automatic logic signed [15:0] mate_adjust(
    input logic signed [15:0] score,
    input logic [5:0]         ply,
    input logic [14:0]        thr,
    input logic               away
  );
    logic signed [17:0] s;
    logic signed [17:0] t;
    logic signed [17:0] p;
    logic signed [17:0] r;
    logic signed [15:0] q;
    s = 18'(score);
    t = $signed({3'b000, thr});
    p = $signed({12'd0, ply});
    r = s;
    if (s > t) begin
      r = away ? s + p : s - p;
    end else if (s < -t) begin
      r = away ? s - p : s + p;
    end
    if (r > 18'sd32767) begin
      q = 16'sh7fff;
    end else if (r < -18'sd32768) begin
      q = 16'sh8000;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

endpackage

FILE: design/ttps_fifo.sv
// ----------------------------------------------------------------------------
// Small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module ttps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: design/ttps_front.sv
// ----------------------------------------------------------------------------
// Transposition table front end
// Accepts requests, classifies them and prepares the stored mate score;
// holds off new requests while a table clear is pending or running.
// ----------------------------------------------------------------------------
module ttps_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic [63:0]        pos_key,
  input  logic [5:0]         ply,
  input  logic [5:0]         depth_in,
  input  logic signed [15:0] alpha,
  input  logic signed [15:0] beta,
  input  logic [24:0]        move_in,
  input  logic signed [15:0] score_in,
  input  logic [1:0]         bound_in,
  input  logic [14:0]        mate_threshold,
  input  logic               mid_full,
  input  logic               sweep_done,
  output logic               mid_push,
  output ttps_pkg::work_t    mid_item
);

  logic clr_busy;
  logic accept;

  assign full     = mid_full | clr_busy;
  assign accept   = push & ~full;
  assign mid_push = accept;

  always_comb begin
    mid_item.kind  = ttps_pkg::req_t'(req_type);
    mid_item.key   = pos_key;
    mid_item.ply   = ply;
    mid_item.depth = depth_in;
    mid_item.alpha = alpha;
    mid_item.beta  = beta;
    mid_item.move  = move_in;
    mid_item.bound = bound_in;
    if (ttps_pkg::req_t'(req_type) == ttps_pkg::REQ_STORE) begin
      mid_item.score = ttps_pkg::mate_adjust(score_in, ply, mate_threshold, 1'b1);
    end else begin
      mid_item.score = score_in;
    end
  end

  // Hold off requests from a clear until its sweep ends; reset sweeps too.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
    end else if (accept && ttps_pkg::req_t'(req_type) == ttps_pkg::REQ_CLEAR) begin
      clr_busy <= 1'b1;
    end else if (sweep_done) begin
      clr_busy <= 1'b0;
    end
  end

endmodule

FILE: design/ttps_back.sv
// ----------------------------------------------------------------------------
// Transposition table back end
// Owns the entry memory: issues probes and stores, sweeps on clear, and
// evaluates probe hits against depth and bounds in the cycle after the read.
// ----------------------------------------------------------------------------
module ttps_back #(
  parameter int ENTRIES   = 4096,
  parameter int MAX_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mid_empty,
  input  ttps_pkg::work_t      mid_item,
  output logic                 mid_pop,
  input  logic [14:0]          mate_threshold,
  input  logic                 res_pop,
  output logic                 res_push,
  output ttps_pkg::result_t    res_item,
  output logic                 sweep_done
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int DEPTH_W = $clog2(MAX_DEPTH);
  localparam int DCMP_W  = (DEPTH_W > 6) ? DEPTH_W : 6;

  logic [63:0]         key_mem   [ENTRIES];
  logic [24:0]         move_mem  [ENTRIES];
  logic signed [15:0]  score_mem [ENTRIES];
  logic [DEPTH_W-1:0]  depth_mem [ENTRIES];
  logic [1:0]          bound_mem [ENTRIES];

  logic [63:0]         rd_key;
  logic [24:0]         rd_move;
  logic signed [15:0]  rd_score;
  logic [DEPTH_W-1:0]  rd_depth;
  logic [1:0]          rd_bound;

  logic                      sweeping;
  logic [IDX_W-1:0]          sweep_idx;
  logic [ttps_pkg::RES_CNT_W-1:0] reserved;
  logic                      issue;
  logic [IDX_W-1:0]          head_idx;
  logic                      rd_en;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx;
  logic [DEPTH_W-1:0]        store_depth;

  logic                      b_valid;
  ttps_pkg::work_t           b_item;
  logic signed [15:0]        adj_score;

  assign head_idx   = mid_item.key[IDX_W-1:0];
  assign issue      = ~mid_empty & ~sweeping &
                      (reserved < ttps_pkg::RES_CNT_W'(ttps_pkg::OQ_DEPTH));
  assign mid_pop    = issue;
  assign rd_en      = issue & (mid_item.kind == ttps_pkg::REQ_PROBE);
  assign wr_en      = sweeping | (issue & (mid_item.kind == ttps_pkg::REQ_STORE));
  assign wr_idx     = sweeping ? sweep_idx : head_idx;
  assign sweep_done = sweeping & (sweep_idx == IDX_W'(ENTRIES - 1));

  always_comb begin
    if (DCMP_W'(mid_item.depth) > DCMP_W'(MAX_DEPTH - 1)) begin
      store_depth = DEPTH_W'(MAX_DEPTH - 1);
    end else begin
      store_depth = DEPTH_W'(mid_item.depth);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx]   <= sweeping ? '0 : mid_item.key;
      move_mem[wr_idx]  <= sweeping ? '0 : mid_item.move;
      score_mem[wr_idx] <= sweeping ? '0 : mid_item.score;
      depth_mem[wr_idx] <= sweeping ? '0 : store_depth;
      bound_mem[wr_idx] <= sweeping ? ttps_pkg::BOUND_NONE : mid_item.bound;
    end
    if (rd_en) begin
      rd_key   <= key_mem[head_idx];
      rd_move  <= move_mem[head_idx];
      rd_score <= score_mem[head_idx];
      rd_depth <= depth_mem[head_idx];
      rd_bound <= bound_mem[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping  <= 1'b1;
      sweep_idx <= '0;
      reserved  <= '0;
      b_valid   <= 1'b0;
    end else begin
      if (sweep_done) begin
        sweeping <= 1'b0;
      end else if (sweeping) begin
        sweep_idx <= sweep_idx + 1'b1;
      end else if (issue && mid_item.kind == ttps_pkg::REQ_CLEAR) begin
        sweeping  <= 1'b1;
        sweep_idx <= '0;
      end
      if (issue && !res_pop) begin
        reserved <= reserved + 1'b1;
      end else if (res_pop && !issue) begin
        reserved <= reserved - 1'b1;
      end
      b_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_item <= mid_item;
    end
  end

  assign adj_score = ttps_pkg::mate_adjust(rd_score, b_item.ply, mate_threshold, 1'b0);
  assign res_push  = b_valid;

  always_comb begin
    res_item = '0;
    if (b_item.kind == ttps_pkg::REQ_PROBE && rd_key == b_item.key) begin
      res_item.key_matched = 1'b1;
      res_item.move        = rd_move;
      if (DCMP_W'(rd_depth) >= DCMP_W'(b_item.depth)) begin
        res_item.score = adj_score;
        unique case (rd_bound)
          ttps_pkg::BOUND_ALPHA: begin
            if (adj_score <= b_item.alpha) begin
              res_item.score  = b_item.alpha;
              res_item.cutoff = 1'b1;
            end
          end
          ttps_pkg::BOUND_BETA: begin
            if (adj_score >= b_item.beta) begin
              res_item.score  = b_item.beta;
              res_item.cutoff = 1'b1;
            end
          end
          ttps_pkg::BOUND_EXACT: begin
            res_item.cutoff = 1'b1;
          end
          default: begin
            res_item.cutoff = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

FILE: design/transposition_table_probe_store_core.sv
// ----------------------------------------------------------------------------
// Transposition table probe/store core
// Direct-mapped, always-replace search result table with mate score handling.
//
// Requests enter through a queue-like port (push/full): probe, store, clear.
// Every request gives one result on the output queue port (empty/pop); store,
// clear and unused requests give an all-zero result. Entries are selected by
// the low bits of pos_key (ENTRIES is a power of two).
// A request is accepted every cycle while full is low; its result passes through
// the middle queue and the registered read of the entry memory to the output queue.
// A clear sweeps the memory one entry per cycle, every entry in turn, with full
// held high; reset runs the same sweep before the first request is taken.
// mate_threshold sits at byte address 0 of the APB port and resets to 29936.
// When the receiver stops popping, up to four results wait in the output
// queue, then the back end holds, the middle queue fills and full rises.
// ----------------------------------------------------------------------------
module transposition_table_probe_store_core #(
  parameter int ENTRIES   = 4096,
  parameter int MAX_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic [63:0]        pos_key,
  input  logic [5:0]         ply,
  input  logic [5:0]         depth_in,
  input  logic signed [15:0] alpha,
  input  logic signed [15:0] beta,
  input  logic [24:0]        move_in,
  input  logic signed [15:0] score_in,
  input  logic [1:0]         bound_in,
  output logic               empty,
  input  logic               pop,
  output logic               key_matched,
  output logic               cutoff,
  output logic [24:0]        move_out,
  output logic signed [15:0] score_out
);

  logic [14:0]       mate_threshold;
  logic              mid_push;
  logic              mid_full;
  logic              mid_empty;
  logic              mid_pop;
  ttps_pkg::work_t   mid_in;
  ttps_pkg::work_t   mid_out;
  logic              res_push;
  logic              res_pop;
  ttps_pkg::result_t res_in;
  ttps_pkg::result_t res_out;
  logic              sweep_done;
  logic              res_full;

  assign pready = 1'b1;
  assign prdata = (paddr == ttps_pkg::REG_MATE_ADDR) ? {17'd0, mate_threshold} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mate_threshold <= ttps_pkg::MATE_RESET;
    end else if (psel && penable && pwrite && paddr == ttps_pkg::REG_MATE_ADDR) begin
      mate_threshold <= pwdata[14:0];
    end
  end

  ttps_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .req_type       (req_type),
    .pos_key        (pos_key),
    .ply            (ply),
    .depth_in       (depth_in),
    .alpha          (alpha),
    .beta           (beta),
    .move_in        (move_in),
    .score_in       (score_in),
    .bound_in       (bound_in),
    .mate_threshold (mate_threshold),
    .mid_full       (mid_full),
    .sweep_done     (sweep_done),
    .mid_push       (mid_push),
    .mid_item       (mid_in)
  );

  ttps_fifo #(
    .WIDTH ($bits(ttps_pkg::work_t)),
    .DEPTH (ttps_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  ttps_back #(
    .ENTRIES   (ENTRIES),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .mid_empty      (mid_empty),
    .mid_item       (mid_out),
    .mid_pop        (mid_pop),
    .mate_threshold (mate_threshold),
    .res_pop        (res_pop),
    .res_push       (res_push),
    .res_item       (res_in),
    .sweep_done     (sweep_done)
  );

  assign res_pop = pop & ~empty;

  ttps_fifo #(
    .WIDTH ($bits(ttps_pkg::result_t)),
    .DEPTH (ttps_pkg::OQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push & ~res_full),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign key_matched = res_out.key_matched;
  assign cutoff      = res_out.cutoff;
  assign move_out    = res_out.move;
  assign score_out   = res_out.score;

endmodule
